FILE: rtl/lpcs_pkg.sv
// Shared types, constants and the noise table of the LPC speech synthesizer.
// No dependencies; imported by lpcs_mul and lpc_speech_synthesizer.
package lpcs_pkg;

    localparam int LPCS_ORDER     = 10;
    localparam int LPCS_FRAC_BITS = 10;

    localparam int DATA_W      = 16;
    localparam int PITCH_W     = 8;
    localparam int PWM_W       = 8;
    localparam int IDX_IN_W    = 4;
    localparam int CFG_INDEX_W = 2;

    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = DATA_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);
    localparam int ACC_W       = 2 * DATA_W;

    localparam int NOISE_DEPTH = 256;
    localparam int NOISE_AW    = $clog2(NOISE_DEPTH);

    localparam logic [PITCH_W-1:0] VOICING_RESET = 8'h15;
    localparam int DE_OFFSET = 32767 / 2;
    localparam int PWM_SHIFT = $clog2(128);
    localparam int PWM_ROUND = (1 << PWM_SHIFT) - 1;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_TICK  = 2'd2
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEEMPH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_VOICING = 2'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    localparam logic signed [DATA_W-1:0] NOISE_ROM [NOISE_DEPTH] = '{
        16'sd494, 16'sd724, -16'sd351, 16'sd36, 16'sd87, 16'sd438, -16'sd35, 16'sd210,
        16'sd389, 16'sd1017, -16'sd246, 16'sd803, 16'sd192, 16'sd329, -16'sd297, -16'sd364,
        -16'sd201, 16'sd707, -16'sd712, -16'sd938, -16'sd744, -16'sd944, 16'sd129, 16'sd1021,
        -16'sd998, 16'sd695, 16'sd798, 16'sd130, 16'sd514, -16'sd202, -16'sd341, -16'sd969,
        16'sd381, -16'sd295, 16'sd101, 16'sd809, -16'sd244, -16'sd46, -16'sd81, -16'sd149,
        16'sd354, -16'sd232, 16'sd219, 16'sd735, 16'sd778, -16'sd532, 16'sd301, 16'sd0,
        16'sd503, -16'sd128, 16'sd244, 16'sd685, -16'sd245, -16'sd299, 16'sd6, -16'sd922,
        16'sd956, -16'sd625, -16'sd383, 16'sd469, -16'sd935, -16'sd600, 16'sd704, -16'sd492,
        16'sd804, -16'sd346, 16'sd801, -16'sd802, 16'sd750, 16'sd644, 16'sd307, -16'sd362,
        -16'sd137, 16'sd949, 16'sd677, -16'sd851, 16'sd718, -16'sd1009, 16'sd172, -16'sd1017,
        16'sd472, -16'sd451, 16'sd4, 16'sd877, -16'sd639, 16'sd337, -16'sd335, -16'sd299,
        -16'sd684, 16'sd319, 16'sd391, -16'sd833, -16'sd405, 16'sd601, -16'sd126, 16'sd718,
        -16'sd860, -16'sd963, -16'sd988, -16'sd650, -16'sd309, -16'sd431, 16'sd116, 16'sd5,
        -16'sd769, -16'sd397, -16'sd427, -16'sd533, -16'sd346, -16'sd136, -16'sd644, 16'sd831,
        16'sd635, 16'sd75, -16'sd492, -16'sd779, 16'sd697, 16'sd270, -16'sd871, 16'sd1022,
        16'sd232, -16'sd161, -16'sd1006, -16'sd808, -16'sd372, -16'sd301, 16'sd456, 16'sd1021,
        -16'sd50, -16'sd685, 16'sd628, 16'sd540, 16'sd235, -16'sd61, -16'sd747, -16'sd369,
        -16'sd998, 16'sd673, -16'sd676, 16'sd519, 16'sd369, 16'sd785, -16'sd332, 16'sd739,
        -16'sd505, 16'sd504, -16'sd113, -16'sd766, -16'sd96, 16'sd678, 16'sd37, 16'sd103,
        -16'sd786, 16'sd524, 16'sd920, 16'sd701, 16'sd297, 16'sd387, -16'sd318, -16'sd115,
        -16'sd92, 16'sd681, -16'sd732, 16'sd522, -16'sd626, -16'sd447, -16'sd610, -16'sd752,
        -16'sd641, -16'sd811, 16'sd967, -16'sd252, 16'sd342, -16'sd958, 16'sd992, 16'sd225,
        -16'sd859, -16'sd433, 16'sd346, 16'sd20, -16'sd932, -16'sd551, -16'sd51, 16'sd531,
        -16'sd500, -16'sd849, 16'sd491, -16'sd397, -16'sd276, 16'sd315, 16'sd500, -16'sd96,
        -16'sd98, -16'sd946, 16'sd838, 16'sd436, -16'sd751, -16'sd736, -16'sd558, 16'sd239,
        -16'sd430, -16'sd171, -16'sd412, 16'sd655, -16'sd705, 16'sd376, -16'sd574, 16'sd308,
        16'sd708, -16'sd772, 16'sd606, 16'sd951, -16'sd17, -16'sd1, 16'sd29, 16'sd575,
        -16'sd732, -16'sd831, 16'sd817, -16'sd703, 16'sd265, 16'sd927, -16'sd676, 16'sd708,
        -16'sd584, -16'sd339, -16'sd143, 16'sd10, -16'sd223, -16'sd224, -16'sd285, -16'sd669,
        16'sd78, -16'sd998, -16'sd87, 16'sd743, 16'sd145, -16'sd825, 16'sd42, 16'sd930,
        -16'sd714, 16'sd52, -16'sd308, -16'sd841, 16'sd481, -16'sd382, 16'sd51, -16'sd127,
        16'sd190, 16'sd65, 16'sd80, 16'sd147, 16'sd63, 16'sd59, -16'sd392, 16'sd871
    };

endpackage

FILE: rtl/lpcs_mul.sv
// Digit-serial signed fixed-point multiplier: one 4-bit digit of b per cycle, MSB first.
// Depends on lpcs_pkg; product is (a*b) >>> FRAC_BITS truncated to 16 bits.
module lpcs_mul
    import lpcs_pkg::*;
#(
    parameter int FRAC_BITS = LPCS_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output mul_status_t              status,
    output logic signed [DATA_W-1:0] prod
);

    localparam int PP_W = DATA_W + DIGIT_W + 1;
    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(DIGITS - 1);

    logic signed [DATA_W-1:0]  a_reg;
    logic        [DATA_W-1:0]  b_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;
    logic [DIGIT_CNT_W-1:0]    cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic signed [DIGIT_W:0]   digit;
    logic signed [PP_W-1:0]    pp;

    always_comb
    begin
        if (cnt_reg == '0)
        begin
            digit = $signed({b_reg[DATA_W-1], b_reg[DATA_W-1 -: DIGIT_W]});
        end
        else
        begin
            digit = $signed({1'b0, b_reg[DATA_W-1 -: DIGIT_W]});
        end
        pp       = PP_W'(a_reg) * PP_W'(digit);
        acc_next = $signed({acc_reg[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}})
                 + $signed({{(ACC_W-PP_W){pp[PP_W-1]}}, pp});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + DIGIT_CNT_W'(1);
                if (cnt_reg == LAST_DIGIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg   <= {b_reg[DATA_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            acc_reg <= acc_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign prod        = acc_reg[FRAC_BITS +: DATA_W];

endmodule

FILE: rtl/lpc_speech_synthesizer.sv
// Top level of the LPC speech synthesizer: command decode, excitation, filter sequencing.
// Depends on lpcs_pkg and lpcs_mul (shared digit-serial multiplier).
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  cmd, coef_index, coef_value, frame_gain,
//                                            pitch_period, new_phrase
//   out      output     out_valid/out_stall  pwm_sample
//   cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Load and frame items leave the block idle, ready for the next item. A tick runs
// ORDER+1 products (voiced) or ORDER+2 (unvoiced) through the shared multiplier; each
// product is issued, runs its 4 digits of b and signals done, then the sample is output.
// Reset clears all state at once; no clearing pass. A stalled output blocks the next
// item only when a tick finishes while the previous sample is still held.
module lpc_speech_synthesizer
    import lpcs_pkg::*;
#(
    parameter int ORDER     = LPCS_ORDER,
    parameter int FRAC_BITS = LPCS_FRAC_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               cmd,
    input  logic [IDX_IN_W-1:0]      coef_index,
    input  logic signed [DATA_W-1:0] coef_value,
    input  logic signed [DATA_W-1:0] frame_gain,
    input  logic [PITCH_W-1:0]       pitch_period,
    input  logic                     new_phrase,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [PWM_W-1:0]         pwm_sample,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    localparam int SEL_W = $clog2(ORDER + 2);
    localparam int IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam logic [SEL_W-1:0] LAST_SEL = SEL_W'(ORDER + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_OUT
    } state_t;

    state_t                   state_reg;
    logic [SEL_W-1:0]         sel_reg;
    logic                     mul_start_reg;
    logic                     out_valid_reg;
    logic [PWM_W-1:0]         pwm_reg;
    logic signed [DATA_W-1:0] deemph_factor_reg;
    logic [PITCH_W-1:0]       voicing_reg;
    logic signed [DATA_W-1:0] gain_reg;
    logic [PITCH_W-1:0]       pitch_reg;
    logic [DATA_W-1:0]        sample_clock_reg;
    logic [DATA_W-1:0]        last_pulse_reg;
    logic [NOISE_AW-1:0]      noise_idx_reg;
    logic signed [DATA_W-1:0] noise_reg;
    logic signed [DATA_W-1:0] deemph_prev_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] coef_reg [ORDER];
    logic signed [DATA_W-1:0] hist_reg [ORDER];

    logic                     accept;
    logic                     commit;
    logic                     unvoiced;
    logic                     pulse_due;
    logic [DATA_W-1:0]        since_pulse;
    logic [SEL_W-1:0]         tap_sel;
    logic [IDX_W-1:0]         tap_idx;
    logic signed [DATA_W-1:0] mul_a;
    logic signed [DATA_W-1:0] mul_b;
    logic signed [DATA_W-1:0] mul_prod;
    mul_status_t              mul_status;
    logic signed [DATA_W-1:0] de_next;
    logic signed [DATA_W:0]   pwm_t;
    logic signed [DATA_W:0]   pwm_adj;
    logic [PWM_W-1:0]         pwm_next;

    assign accept      = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign pwm_sample  = pwm_reg;
    assign commit      = (state_reg == S_MUL) && mul_status.done && (sel_reg == LAST_SEL);

    assign unvoiced    = (pitch_reg < voicing_reg);
    assign since_pulse = sample_clock_reg - last_pulse_reg;
    assign pulse_due   = (since_pulse >= {{(DATA_W-PITCH_W){1'b0}}, pitch_reg});

    assign tap_sel     = sel_reg - SEL_W'(1);
    assign tap_idx     = tap_sel[IDX_W-1:0];

    always_comb
    begin
        if (sel_reg == '0)
        begin
            mul_a = gain_reg;
            mul_b = noise_reg;
        end
        else if (sel_reg == LAST_SEL)
        begin
            mul_a = deemph_factor_reg;
            mul_b = deemph_prev_reg;
        end
        else
        begin
            mul_a = coef_reg[tap_idx];
            mul_b = hist_reg[tap_idx];
        end
    end

    assign de_next  = x_reg + mul_prod;
    assign pwm_t    = $signed({deemph_prev_reg[DATA_W-1], deemph_prev_reg})
                    + $signed((DATA_W+1)'(DE_OFFSET));
    assign pwm_adj  = pwm_t + (pwm_t[DATA_W] ? $signed((DATA_W+1)'(PWM_ROUND))
                                             : $signed({(DATA_W+1){1'b0}}));
    assign pwm_next = pwm_adj[PWM_SHIFT +: PWM_W];

    lpcs_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .a      (mul_a),
        .b      (mul_b),
        .status (mul_status),
        .prod   (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            sel_reg           <= '0;
            mul_start_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
            pwm_reg           <= '0;
            deemph_factor_reg <= '0;
            voicing_reg       <= VOICING_RESET;
            gain_reg          <= '0;
            pitch_reg         <= '0;
            sample_clock_reg  <= '0;
            last_pulse_reg    <= '0;
            noise_idx_reg     <= '0;
            noise_reg         <= '0;
            deemph_prev_reg   <= '0;
            x_reg             <= '0;
        end
        else
        begin
            mul_start_reg <= 1'b0;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_DEEMPH:  deemph_factor_reg <= $signed(cfg_data);
                    CFG_VOICING: voicing_reg       <= cfg_data[PITCH_W-1:0];
                    default:     ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        unique case (cmd_t'(cmd))
                            CMD_FRAME:
                            begin
                                gain_reg  <= frame_gain;
                                pitch_reg <= pitch_period;
                                if (new_phrase)
                                begin
                                    sample_clock_reg <= '0;
                                end
                            end
                            CMD_TICK:
                            begin
                                noise_reg     <= NOISE_ROM[noise_idx_reg];
                                noise_idx_reg <= noise_idx_reg + NOISE_AW'(1);
                                x_reg         <= '0;
                                if (unvoiced)
                                begin
                                    sel_reg <= '0;
                                end
                                else
                                begin
                                    sel_reg <= SEL_W'(1);
                                    if (pulse_due)
                                    begin
                                        last_pulse_reg <= sample_clock_reg;
                                        x_reg          <= gain_reg <<< 2;
                                    end
                                end
                                mul_start_reg <= 1'b1;
                                state_reg     <= S_MUL;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL:
                begin
                    if (mul_status.done)
                    begin
                        if (sel_reg == LAST_SEL)
                        begin
                            deemph_prev_reg  <= de_next;
                            sample_clock_reg <= sample_clock_reg + DATA_W'(1);
                            state_reg        <= S_OUT;
                        end
                        else
                        begin
                            x_reg         <= x_reg + mul_prod;
                            sel_reg       <= sel_reg + SEL_W'(1);
                            mul_start_reg <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        pwm_reg       <= pwm_next;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ORDER; k++)
            begin
                coef_reg[k] <= '0;
                hist_reg[k] <= '0;
            end
        end
        else
        begin
            if (accept && (cmd_t'(cmd) == CMD_LOAD)
                && ({1'b0, coef_index} < (IDX_IN_W+1)'(ORDER)))
            begin
                coef_reg[coef_index[IDX_W-1:0]] <= coef_value;
            end
            if (accept && (cmd_t'(cmd) == CMD_FRAME))
            begin
                for (int k = 0; k < ORDER; k++)
                begin
                    hist_reg[k] <= '0;
                end
            end
            else if (commit)
            begin
                hist_reg[0] <= x_reg;
                for (int k = 1; k < ORDER; k++)
                begin
                    hist_reg[k] <= hist_reg[k-1];
                end
            end
        end
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_status.done |-> (state_reg == S_MUL))
        else $error("multiplier done outside filter sequencing");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> (!mul_status.busy && !mul_start_reg))
        else $error("item taken while multiplier active");

    assert property (@(posedge clk) disable iff (!rst_n)
        sel_reg <= LAST_SEL)
        else $error("product select out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        mul_start_reg |=> (mul_status.busy && !mul_status.done))
        else $error("multiplier did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !mul_status.busy)
        else $error("sample output while multiplier busy");
`endif

endmodule
